/* hdl/ssc_pkg.sv */
// ssc_pkg: widths, constants and shared types of the sphere-sphere contact block.
// No dependencies; used by ssc_isqrt, ssc_div, the top level and the bench.
`timescale 1ns / 1ps

package ssc_pkg;

    localparam int CW         = 32;       // center / contact width
    localparam int RW         = 31;       // radius / depth width
    localparam int LW         = 32;       // center distance and radius sum width
    localparam int SQW        = 66;       // sum of three squares
    localparam int QW         = 31;       // normal magnitude, Q1.30
    localparam int NORM_SHIFT = 30;

    localparam logic [CW-1:0] NORM_ONE  = 32'h4000_0000;
    localparam logic [RW-1:0] DEPTH_MAX = 31'h7FFF_FFFF;

    // Per-item data carried alongside the square root and divider pipelines.
    typedef struct packed {
        logic                  collide;
        logic [2:0][CW-1:0]    ctr_a;
        logic [RW-1:0]         ra;
        logic [LW-1:0]         rsum;
        logic [2:0][LW-1:0]    dmag;
        logic [2:0]            dneg;
    } side_t;

    // Pipeline control handed to the sub-pipelines.
    typedef struct packed {
        logic en;
        logic valid;
    } ctl_t;

endpackage

/* hdl/ssc_isqrt.sv */
// ssc_isqrt: pipelined integer square root, one result bit per register stage.
// Depends on ssc_pkg.
`timescale 1ns / 1ps

module ssc_isqrt (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ssc_pkg::ctl_t             ctl,
    input  logic [2*ssc_pkg::LW-1:0]  rad,
    input  ssc_pkg::side_t            side_in,
    output logic                      valid_out,
    output logic [ssc_pkg::LW-1:0]    root,
    output ssc_pkg::side_t            side_out
);

    localparam int LW  = ssc_pkg::LW;
    localparam int SQW = ssc_pkg::SQW;

    logic [SQW-1:0]       rem_reg  [LW];
    logic [LW-1:0]        res_reg  [LW];
    ssc_pkg::side_t       side_reg [LW];
    logic [LW-1:0]        vld_reg;

    for (genvar i = 0; i < LW; i++) begin : g_stg
        localparam int K = LW - 1 - i;
        logic [SQW-1:0]   rem_cur;
        logic [SQW-1:0]   trial;
        logic [LW-1:0]    res_cur;
        logic             v_cur;
        ssc_pkg::side_t   sd_cur;

        if (i == 0) begin : g_first
            assign rem_cur = {{(SQW-2*LW){1'b0}}, rad};
            assign res_cur = '0;
            assign v_cur   = ctl.valid;
            assign sd_cur  = side_in;
        end
        else begin : g_rest
            assign rem_cur = rem_reg[i-1];
            assign res_cur = res_reg[i-1];
            assign v_cur   = vld_reg[i-1];
            assign sd_cur  = side_reg[i-1];
        end

        // (res + 2^K)^2 - res^2
        assign trial = ({{(SQW-LW){1'b0}}, res_cur} << (K + 1)) + (SQW'(1) << (2 * K));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i] <= 1'b0;
            else if (ctl.en)
                vld_reg[i] <= v_cur;
        end

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                side_reg[i] <= sd_cur;
                if (rem_cur >= trial)
                begin
                    rem_reg[i] <= rem_cur - trial;
                    res_reg[i] <= res_cur | (LW'(1) << K);
                end
                else
                begin
                    rem_reg[i] <= rem_cur;
                    res_reg[i] <= res_cur;
                end
            end
        end
    end

    assign valid_out = vld_reg[LW-1];
    assign root      = res_reg[LW-1];
    assign side_out  = side_reg[LW-1];

endmodule

/* hdl/ssc_div.sv */
// ssc_div: three-lane pipelined restoring divider, one quotient bit per stage.
// Computes (dmag << 30) / len for each axis; needs dmag <= len. Depends on ssc_pkg.
`timescale 1ns / 1ps

module ssc_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ssc_pkg::ctl_t                 ctl,
    input  logic [ssc_pkg::LW-1:0]        len,
    input  ssc_pkg::side_t                side_in,
    output logic                          valid_out,
    output logic [2:0][ssc_pkg::QW-1:0]   quot,
    output logic [ssc_pkg::LW-1:0]        len_out,
    output ssc_pkg::side_t                side_out
);

    localparam int LW = ssc_pkg::LW;
    localparam int QW = ssc_pkg::QW;

    logic [2:0][LW-1:0]   rem_reg  [QW];
    logic [2:0][QW-1:0]   q_reg    [QW];
    logic [LW-1:0]        len_reg  [QW];
    ssc_pkg::side_t       side_reg [QW];
    logic [QW-1:0]        vld_reg;

    for (genvar j = 0; j < QW; j++) begin : g_stg
        logic [2:0][LW:0]     cur;
        logic [2:0][QW-1:0]   q_cur;
        logic [LW-1:0]        len_cur;
        logic                 v_cur;
        ssc_pkg::side_t       sd_cur;

        if (j == 0) begin : g_first
            always_comb
            begin
                for (int l = 0; l < 3; l++)
                    cur[l] = {1'b0, side_in.dmag[l]};
            end
            assign q_cur   = '0;
            assign len_cur = len;
            assign v_cur   = ctl.valid;
            assign sd_cur  = side_in;
        end
        else begin : g_rest
            always_comb
            begin
                for (int l = 0; l < 3; l++)
                    cur[l] = {rem_reg[j-1][l], 1'b0};
            end
            assign q_cur   = q_reg[j-1];
            assign len_cur = len_reg[j-1];
            assign v_cur   = vld_reg[j-1];
            assign sd_cur  = side_reg[j-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[j] <= 1'b0;
            else if (ctl.en)
                vld_reg[j] <= v_cur;
        end

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                len_reg[j]  <= len_cur;
                side_reg[j] <= sd_cur;
                for (int l = 0; l < 3; l++)
                begin
                    if (cur[l] >= {1'b0, len_cur})
                    begin
                        rem_reg[j][l] <= LW'(cur[l] - {1'b0, len_cur});
                        q_reg[j][l]   <= {q_cur[l][QW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[j][l] <= cur[l][LW-1:0];
                        q_reg[j][l]   <= {q_cur[l][QW-2:0], 1'b0};
                    end
                end
            end
        end
    end

    assign valid_out = vld_reg[QW-1];
    assign quot      = q_reg[QW-1];
    assign len_out   = len_reg[QW-1];
    assign side_out  = side_reg[QW-1];

endmodule

/* hdl/sphere_sphere_contact.sv */
// sphere_sphere_contact: top level, sphere pair in, contact manifold out.
// Depends on ssc_pkg, ssc_isqrt and ssc_div.
//
// Takes one sphere pair per clock unless the output stalls; its contact manifold
// is built in four stages of difference, squaring and compare, 32 square root
// stages (one root bit each), 31 divider stages (one normal bit each, three
// axes side by side) and three stages of depth, scaling and saturation. The
// pipeline moves as a whole: it advances whenever the output register is
// empty or its result is taken, so in_ready follows out_ready or an empty
// output stage. Non-overlapping or coincident pairs give normal (0,0,1),
// maximum depth and a zero contact point.
`timescale 1ns / 1ps

module sphere_sphere_contact (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [ssc_pkg::CW-1:0]       center_a_x,
    input  logic signed [ssc_pkg::CW-1:0]       center_a_y,
    input  logic signed [ssc_pkg::CW-1:0]       center_a_z,
    input  logic        [ssc_pkg::RW-1:0]       radius_a,
    input  logic signed [ssc_pkg::CW-1:0]       center_b_x,
    input  logic signed [ssc_pkg::CW-1:0]       center_b_y,
    input  logic signed [ssc_pkg::CW-1:0]       center_b_z,
    input  logic        [ssc_pkg::RW-1:0]       radius_b,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                colliding,
    output logic signed [ssc_pkg::CW-1:0]       normal_x,
    output logic signed [ssc_pkg::CW-1:0]       normal_y,
    output logic signed [ssc_pkg::CW-1:0]       normal_z,
    output logic        [ssc_pkg::RW-1:0]       depth,
    output logic signed [ssc_pkg::CW-1:0]       contact_x,
    output logic signed [ssc_pkg::CW-1:0]       contact_y,
    output logic signed [ssc_pkg::CW-1:0]       contact_z
);

    localparam int CW  = ssc_pkg::CW;
    localparam int RW  = ssc_pkg::RW;
    localparam int LW  = ssc_pkg::LW;
    localparam int SQW = ssc_pkg::SQW;
    localparam int QW  = ssc_pkg::QW;
    localparam int NS  = ssc_pkg::NORM_SHIFT;
    localparam int PW  = QW + LW;          // product width
    localparam int MW  = PW - NS + 1;      // rounded magnitude width
    localparam int SW  = MW + 2;           // contact sum width

    logic en;
    logic out_valid_reg;

    assign en       = out_ready | ~out_valid_reg;
    assign in_ready = en;

    // ---- stage 0: input register
    logic                    v0_reg;
    logic [2:0][CW-1:0]      a0_reg, b0_reg;
    logic [RW-1:0]           ra0_reg, rb0_reg;

    // ---- stage 1: differences, radius sum
    logic                    v1_reg;
    ssc_pkg::side_t          sd1_reg;

    // ---- stage 2: squares
    logic                    v2_reg;
    ssc_pkg::side_t          sd2_reg;
    logic [2:0][2*LW-1:0]    sq2_reg;
    logic [2*LW-1:0]         r2_reg;

    // ---- stage 3: distance squared and overlap test
    logic                    v3_reg;
    ssc_pkg::side_t          sd3_reg;
    ssc_pkg::side_t          sd3_next;
    logic [2*LW-1:0]         s3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    logic signed [CW:0]  dif [3];
    logic [SQW-1:0]      ssum;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            dif[i] = $signed({b0_reg[i][CW-1], b0_reg[i]}) - $signed({a0_reg[i][CW-1], a0_reg[i]});
        ssum = {2'b00, sq2_reg[0]} + {2'b00, sq2_reg[1]} + {2'b00, sq2_reg[2]};
        sd3_next         = sd2_reg;
        sd3_next.collide = (ssum != '0) && (ssum <= {2'b00, r2_reg});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a0_reg  <= {center_a_z, center_a_y, center_a_x};
            b0_reg  <= {center_b_z, center_b_y, center_b_x};
            ra0_reg <= radius_a;
            rb0_reg <= radius_b;

            sd1_reg.collide <= 1'b0;
            sd1_reg.ctr_a   <= a0_reg;
            sd1_reg.ra      <= ra0_reg;
            sd1_reg.rsum    <= {1'b0, ra0_reg} + {1'b0, rb0_reg};
            for (int i = 0; i < 3; i++)
            begin
                sd1_reg.dneg[i] <= dif[i][CW];
                sd1_reg.dmag[i] <= dif[i][CW] ? LW'(-dif[i]) : LW'(dif[i]);
            end

            sd2_reg <= sd1_reg;
            for (int i = 0; i < 3; i++)
                sq2_reg[i] <= sd1_reg.dmag[i] * sd1_reg.dmag[i];
            r2_reg <= sd1_reg.rsum * sd1_reg.rsum;

            sd3_reg <= sd3_next;
            s3_reg  <= ssum[2*LW-1:0];
        end
    end

    // ---- square root and divide pipelines
    logic                    vr;
    logic [LW-1:0]           root;
    ssc_pkg::side_t          sdr;
    logic                    vq;
    logic [2:0][QW-1:0]      quot;
    logic [LW-1:0]           lenq;
    ssc_pkg::side_t          sdq;

    ssc_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       ('{en: en, valid: v3_reg}),
        .rad       (s3_reg),
        .side_in   (sd3_reg),
        .valid_out (vr),
        .root      (root),
        .side_out  (sdr)
    );

    ssc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       ('{en: en, valid: vr}),
        .len       (root),
        .side_in   (sdr),
        .valid_out (vq),
        .quot      (quot),
        .len_out   (lenq),
        .side_out  (sdq)
    );

    // ---- stage 4: depth, contact distance
    logic                    v4_reg;
    ssc_pkg::side_t          sd4_reg;
    logic [2:0][QW-1:0]      q4_reg;
    logic [RW-1:0]           dep4_reg;
    logic [LW-1:0]           dtpm4_reg;
    logic                    dtpn4_reg;

    // ---- stage 5: scaled offsets
    logic                    v5_reg;
    ssc_pkg::side_t          sd5_reg;
    logic [2:0][QW-1:0]      q5_reg;
    logic [RW-1:0]           dep5_reg;
    logic [2:0][PW-1:0]      p5_reg;
    logic [2:0]              pn5_reg;

    // ---- stage 6: output register
    logic                    coll_reg;
    logic [2:0][CW-1:0]      nrm_reg;
    logic [RW-1:0]           dep_reg;
    logic [2:0][CW-1:0]      ctc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg        <= vq;
            v5_reg        <= v4_reg;
            out_valid_reg <= v5_reg;
        end
    end

    logic [LW-1:0]           gap;
    logic [RW-1:0]           dep_c;
    logic signed [LW:0]      dtp;
    logic [MW-1:0]           mag    [3];
    logic signed [SW-1:0]    csum   [3];
    logic [CW-1:0]           csat   [3];
    logic [CW-1:0]           nsg    [3];

    always_comb
    begin
        gap   = sdq.rsum - lenq;
        dep_c = gap[LW-1:1];
        dtp   = $signed({2'b00, sdq.ra}) - $signed({2'b00, dep_c});
        for (int i = 0; i < 3; i++)
        begin
            mag[i]  = MW'((p5_reg[i] + (PW'(1) << (NS - 1))) >> NS);
            csum[i] = $signed({{(SW-CW){sd5_reg.ctr_a[i][CW-1]}}, sd5_reg.ctr_a[i]})
                    + (pn5_reg[i] ? -$signed({1'b0, mag[i]}) : $signed({1'b0, mag[i]}));
            if (csum[i] > $signed(SW'(32'h7FFF_FFFF)))
                csat[i] = 32'h7FFF_FFFF;
            else if (csum[i] < -$signed(SW'(33'h0_8000_0000)))
                csat[i] = 32'h8000_0000;
            else
                csat[i] = csum[i][CW-1:0];
            nsg[i] = sd5_reg.dneg[i] ? CW'(-{1'b0, q5_reg[i]}) : CW'({1'b0, q5_reg[i]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sd4_reg   <= sdq;
            q4_reg    <= quot;
            dep4_reg  <= dep_c;
            dtpn4_reg <= dtp[LW];
            dtpm4_reg <= dtp[LW] ? LW'(-dtp) : LW'(dtp);

            sd5_reg  <= sd4_reg;
            q5_reg   <= q4_reg;
            dep5_reg <= dep4_reg;
            for (int i = 0; i < 3; i++)
            begin
                p5_reg[i]  <= q4_reg[i] * dtpm4_reg;
                pn5_reg[i] <= sd4_reg.dneg[i] ^ dtpn4_reg;
            end

            coll_reg <= sd5_reg.collide;
            if (sd5_reg.collide)
            begin
                dep_reg <= dep5_reg;
                for (int i = 0; i < 3; i++)
                begin
                    nrm_reg[i] <= nsg[i];
                    ctc_reg[i] <= csat[i];
                end
            end
            else
            begin
                dep_reg    <= ssc_pkg::DEPTH_MAX;
                nrm_reg[0] <= '0;
                nrm_reg[1] <= '0;
                nrm_reg[2] <= ssc_pkg::NORM_ONE;
                ctc_reg    <= '0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign colliding = coll_reg;
    assign normal_x  = nrm_reg[0];
    assign normal_y  = nrm_reg[1];
    assign normal_z  = nrm_reg[2];
    assign depth     = dep_reg;
    assign contact_x = ctc_reg[0];
    assign contact_y = ctc_reg[1];
    assign contact_z = ctc_reg[2];

endmodule

/* hdl/ssc_checker.sv */
// ssc_checker: port-level checks of sphere_sphere_contact, bound to the top level.
// Depends on the top level's port list only.
`timescale 1ns / 1ps

module ssc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic               colliding,
    input logic signed [31:0] normal_x,
    input logic signed [31:0] normal_y,
    input logic signed [31:0] normal_z,
    input logic        [30:0] depth,
    input logic signed [31:0] contact_x,
    input logic signed [31:0] contact_y,
    input logic signed [31:0] contact_z
);

    // a stalled result holds: valid, colliding, normal_x, depth and contact_x are checked
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(normal_x) && $stable(depth)
            && $stable(contact_x) && $stable(colliding))
        else $error("result changed while stalled");

    // miss gives the fixed manifold
    a_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !colliding |-> normal_x == 0 && normal_y == 0
            && normal_z == 32'sh4000_0000 && depth == 31'h7FFF_FFFF
            && contact_x == 0 && contact_y == 0 && contact_z == 0)
        else $error("bad manifold for separated spheres");

    // normal components stay within one
    a_unit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && colliding |-> normal_x <= 32'sh4000_0000 && normal_x >= -32'sh4000_0000
            && normal_y <= 32'sh4000_0000 && normal_y >= -32'sh4000_0000
            && normal_z <= 32'sh4000_0000 && normal_z >= -32'sh4000_0000)
        else $error("normal component out of range");

    // pipeline takes input whenever the output side is free
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid || out_ready |-> in_ready)
        else $error("input stalled with free output");

endmodule

bind sphere_sphere_contact ssc_checker u_ssc_checker (.*);

/* sim/contact_checker.sv */
// contact_checker: watches both channels of sphere_sphere_contact, predicts each
// contact manifold and compares it field by field. Depends on ssc_pkg.
`timescale 1ns / 1ps

module contact_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic signed [ssc_pkg::CW-1:0] center_a_x,
    input  logic signed [ssc_pkg::CW-1:0] center_a_y,
    input  logic signed [ssc_pkg::CW-1:0] center_a_z,
    input  logic        [ssc_pkg::RW-1:0] radius_a,
    input  logic signed [ssc_pkg::CW-1:0] center_b_x,
    input  logic signed [ssc_pkg::CW-1:0] center_b_y,
    input  logic signed [ssc_pkg::CW-1:0] center_b_z,
    input  logic        [ssc_pkg::RW-1:0] radius_b,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic                          colliding,
    input  logic signed [ssc_pkg::CW-1:0] normal_x,
    input  logic signed [ssc_pkg::CW-1:0] normal_y,
    input  logic signed [ssc_pkg::CW-1:0] normal_z,
    input  logic        [ssc_pkg::RW-1:0] depth,
    input  logic signed [ssc_pkg::CW-1:0] contact_x,
    input  logic signed [ssc_pkg::CW-1:0] contact_y,
    input  logic signed [ssc_pkg::CW-1:0] contact_z,
    output int                            pending,
    output int                            errors
);

    typedef struct packed {
        logic                         hit;
        logic [2:0][ssc_pkg::CW-1:0]  nrm;
        logic [ssc_pkg::RW-1:0]       dep;
        logic [2:0][ssc_pkg::CW-1:0]  cpt;
    } manifold_t;

    manifold_t manifolds_due[$];

    function automatic logic [32:0] root_floor(logic [65:0] v);
        logic [32:0] res;
        logic [66:0] trial;
        res = '0;
        for (int b = 32; b >= 0; b--) begin
            trial = ({34'd0, res} | (67'd1 << b));
            if (trial * trial <= {1'b0, v})
                res = trial[32:0];
        end
        return res;
    endfunction

    function automatic manifold_t sphere_contact(
        logic [2:0][ssc_pkg::CW-1:0] ca, logic [2:0][ssc_pkg::CW-1:0] cb,
        logic [ssc_pkg::RW-1:0] ra, logic [ssc_pkg::RW-1:0] rb);
        manifold_t m;
        logic signed [33:0] dv [3];
        logic [32:0] mag [3];
        logic [65:0] dist2;
        logic [65:0] rsq;
        logic [32:0] rs, len, dp;
        logic [63:0] q;
        logic signed [33:0] dtp;
        logic [96:0] prod;
        logic [66:0] off_mag;
        logic signed [69:0] sum;
        logic neg;
        dist2 = '0;
        for (int i = 0; i < 3; i++) begin
            dv[i] = $signed({{2{cb[i][31]}}, cb[i]}) - $signed({{2{ca[i][31]}}, ca[i]});
            mag[i] = dv[i] < 0 ? 33'(-dv[i]) : 33'(dv[i]);
            dist2 += 66'(mag[i]) * 66'(mag[i]);
        end
        rs = 33'(ra) + 33'(rb);
        rsq = 66'(rs) * 66'(rs);
        m.hit = 1'b0;
        m.nrm[0] = '0;
        m.nrm[1] = '0;
        m.nrm[2] = ssc_pkg::NORM_ONE;
        m.dep = ssc_pkg::DEPTH_MAX;
        m.cpt = '0;
        // upper bits of the sum were dropped by the 64-bit form; any excess means apart
        if (dist2 == 0 || dist2 > rsq || dist2[65:64] != 0)
            return m;
        len = root_floor(dist2);
        if (len == 0)
            len = 1;
        m.hit = 1'b1;
        dp = (rs >= len ? rs - len : len - rs) >> 1;
        if (dp > 33'(ssc_pkg::DEPTH_MAX))
            dp = 33'(ssc_pkg::DEPTH_MAX);
        m.dep = dp[ssc_pkg::RW-1:0];
        dtp = $signed({3'b0, ra}) - $signed({1'b0, dp});
        for (int i = 0; i < 3; i++) begin
            q = (64'(mag[i]) << ssc_pkg::NORM_SHIFT) / 64'(len);
            if (q > 64'(ssc_pkg::NORM_ONE))
                q = 64'(ssc_pkg::NORM_ONE);
            m.nrm[i] = dv[i] < 0 ? ssc_pkg::CW'(-q) : ssc_pkg::CW'(q);
            prod = 97'(q) * 97'(dtp < 0 ? -dtp : dtp);
            off_mag = 67'((prod + (97'd1 << (ssc_pkg::NORM_SHIFT - 1))) >> ssc_pkg::NORM_SHIFT);
            neg = (dv[i] < 0 && q != 0) != (dtp < 0);
            sum = $signed({{38{ca[i][31]}}, ca[i]})
                + (neg ? -$signed({3'b0, off_mag}) : $signed({3'b0, off_mag}));
            if (sum > 70'sd2147483647)
                m.cpt[i] = 32'h7FFF_FFFF;
            else if (sum < -70'sd2147483648)
                m.cpt[i] = 32'h8000_0000;
            else
                m.cpt[i] = sum[31:0];
        end
        return m;
    endfunction

    manifold_t seen, want;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            errors <= 0;
            pending <= 0;
        end else begin
            if (in_valid && in_ready)
                manifolds_due.insert(manifolds_due.size(), sphere_contact(
                    {center_a_z, center_a_y, center_a_x},
                    {center_b_z, center_b_y, center_b_x}, radius_a, radius_b));
            if (out_valid && out_ready) begin
                seen = {colliding, {normal_z, normal_y, normal_x}, depth,
                        {contact_z, contact_y, contact_x}};
                if (manifolds_due.size() == 0) begin
                    if (errors < 10)
                        $display("unexpected result transfer at %0t", $time);
                    errors <= errors + 1;
                end else begin
                    want = manifolds_due.pop_front();
                    if (seen !== want) begin
                        if (errors < 10)
                            $display("mismatch at %0t: exp hit=%0d n=%0d,%0d,%0d d=%0d c=%0d,%0d,%0d got hit=%0d n=%0d,%0d,%0d d=%0d c=%0d,%0d,%0d",
                                $time, want.hit, $signed(want.nrm[0]), $signed(want.nrm[1]),
                                $signed(want.nrm[2]), want.dep, $signed(want.cpt[0]),
                                $signed(want.cpt[1]), $signed(want.cpt[2]),
                                colliding, normal_x, normal_y, normal_z, depth,
                                contact_x, contact_y, contact_z);
                        errors <= errors + 1;
                    end
                end
            end
            pending <= manifolds_due.size();
        end
    end
endmodule

/* sim/testbench.sv */
// testbench: stimulus and verdict for sphere_sphere_contact.
// Depends on ssc_pkg, the block's RTL and contact_checker.
`timescale 1ns / 1ps

module testbench;

    localparam int LATENCY = 70;
    localparam int STALL_LIMIT = 5000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0, out_ready = 1'b0;
    logic in_ready, out_valid;
    logic signed [ssc_pkg::CW-1:0] ax = '0, ay = '0, az = '0, bx = '0, by = '0, bz = '0;
    logic [ssc_pkg::RW-1:0] ra = '0, rb = '0;
    logic colliding;
    logic signed [ssc_pkg::CW-1:0] normal_x, normal_y, normal_z;
    logic signed [ssc_pkg::CW-1:0] contact_x, contact_y, contact_z;
    logic [ssc_pkg::RW-1:0] depth;
    int pending, errors;
    int idle_cycles = 0;
    bit hold_off = 1;

    always #4 clk = ~clk;

    sphere_sphere_contact u_top (
        .clk, .rst_n, .in_valid, .in_ready,
        .center_a_x(ax), .center_a_y(ay), .center_a_z(az), .radius_a(ra),
        .center_b_x(bx), .center_b_y(by), .center_b_z(bz), .radius_b(rb),
        .out_valid, .out_ready, .colliding, .normal_x, .normal_y, .normal_z,
        .depth, .contact_x, .contact_y, .contact_z);

    contact_checker u_checker (
        .clk, .rst_n, .in_valid, .in_ready,
        .center_a_x(ax), .center_a_y(ay), .center_a_z(az), .radius_a(ra),
        .center_b_x(bx), .center_b_y(by), .center_b_z(bz), .radius_b(rb),
        .out_valid, .out_ready, .colliding, .normal_x, .normal_y, .normal_z,
        .depth, .contact_x, .contact_y, .contact_z, .pending, .errors);

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // valid stays up between back-to-back transfers; it drops only for a gap
    task automatic send_pair(logic [ssc_pkg::CW-1:0] cax, cay, caz, rad_a,
                             logic [ssc_pkg::CW-1:0] cbx, cby, cbz, rad_b);
        int g;
        g = gap_len();
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        ax <= cax; ay <= cay; az <= caz; ra <= rad_a[ssc_pkg::RW-1:0];
        bx <= cbx; by <= cby; bz <= cbz; rb <= rad_b[ssc_pkg::RW-1:0];
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // random offset around a center, scale picks near or far pairs
    function automatic logic [ssc_pkg::CW-1:0] near(logic [ssc_pkg::CW-1:0] c, int bits);
        logic [ssc_pkg::CW-1:0] o;
        o = $urandom() >> (32 - bits);
        return c + o - (32'd1 << (bits - 1));
    endfunction

    task automatic random_pair();
        logic [ssc_pkg::CW-1:0] x, y, z;
        int bits, p;
        p = $urandom_range(0, 9);
        x = $urandom(); y = $urandom(); z = $urandom();
        if (p < 7) begin
            bits = $urandom_range(2, 31);
            send_pair(x, y, z, $urandom() >> (32 - bits),
                      near(x, bits), near(y, bits), near(z, bits), $urandom() >> (32 - bits));
        end else if (p < 9) begin
            send_pair(x, y, z, $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        end else begin
            send_pair(x, y, z, $urandom(), x, y, z, $urandom());
        end
    endtask

    // receiver: one long hold-off first so the pipeline fills and stalls the input
    initial begin
        int g;
        @(posedge rst_n);
        repeat (200) @(negedge clk);
        hold_off = 0;
        forever begin
            @(negedge clk);
            g = gap_len();
            if (g == 0) begin
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b0;
                repeat (g - 1) @(negedge clk);
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || hold_off)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        // extremes, touching, coincident, far apart, saturated contact
        send_pair(0, 0, 0, 65536, 0, 0, 0, 65536);
        send_pair(0, 0, 0, 65536, 32'd131072, 0, 0, 65536);
        send_pair(0, 0, 0, 65536, 32'd131073, 0, 0, 65536);
        send_pair(0, 0, 0, 65536, 0, 32'hFFFF_0000, 0, 65536);
        send_pair(0, 0, 0, 65536, 0, 0, 32'd65536, 65536);
        send_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '1,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '1);
        send_pair(32'h8000_0000, 0, 0, '1, 32'h7FFF_FFFF, 0, 0, '1);
        send_pair(32'h7FFF_FFFF, 0, 0, '1, 32'h7FFF_FFF0, 0, 0, '1);
        send_pair(32'h8000_0000, 0, 0, '1, 32'h8000_0010, 0, 0, '1);
        send_pair(0, 0, 0, 0, 1, 0, 0, 1);
        send_pair(0, 0, 0, 0, 0, 0, 0, 0);
        send_pair(5, 5, 5, 100, 3, 7, 2, 0);
        send_pair(0, 0, 0, 10, 100, 100, 100, 10);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h5555_5555,
                  32'h1, 32'h1, 32'h1, 32'h2AAA_AAAA);
        send_pair(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 32'h0100_0000,
                  32'h1234_0000, 32'h9ABC_0000, 32'h0F0F_0000, 32'h0010_0000);
        repeat (500) random_pair();
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
